// ===== design/srv6_routing_header_strip_top_defines.svh =====
// assertion macros used by the srv6 header strip design
`ifndef SRV6_ROUTING_HEADER_STRIP_TOP_DEFINES_SVH
`define SRV6_ROUTING_HEADER_STRIP_TOP_DEFINES_SVH

// plain property, checked on every rising edge outside reset
`define SRV6S_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srv6s assertion failed");

// same-cycle implication
`define SRV6S_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `SRV6S_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// ===== design/srv6s_pkg.sv =====
// types and constants of the srv6 routing header strip block
package srv6s_pkg;

  localparam int HOLD_DEPTH  = 56;
  localparam int HDR_BYTES   = 54;
  localparam int COUNT_WIDTH = 14;
  localparam int COUNT_MAX   = 16383;
  localparam int CNT_WIDTH   = 6;
  localparam int STRIP_WIDTH = 12;
  localparam int LIMIT_WIDTH = 13;

  localparam logic [7:0] ETH_TYPE_HI   = 8'h86;
  localparam logic [7:0] ETH_TYPE_LO   = 8'hDD;
  localparam logic [7:0] NH_ROUTING    = 8'd43;
  localparam logic [7:0] NH_TCP        = 8'd6;
  localparam logic [7:0] NH_UDP        = 8'd17;
  localparam int         MIN_FRAME     = 110;
  localparam int         TAIL_BYTES    = 74;

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_STRIP = 2'd1;
  localparam logic [1:0] VERDICT_DROP  = 2'd2;

  typedef enum logic [2:0] {
    S_FILL,
    S_ALIGN,
    S_DECIDE,
    S_DRAIN,
    S_STREAM
  } state_e;

  typedef enum logic [1:0] {
    MODE_UNDECIDED,
    MODE_PASS,
    MODE_STRIP
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic [1:0] verdict;
  } out_beat_t;

  typedef struct packed {
    logic       shift;
    logic [7:0] din;
  } hold_ctl_t;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] b12;
    logic [7:0] b13;
    logic [7:0] b18;
    logic [7:0] b19;
    logic [7:0] b20;
    logic [7:0] b54;
    logic [7:0] b55;
  } hold_taps_t;

endpackage

// ===== design/srv6s_stream_if.sv =====
// valid/ready stream channel with a typed payload
interface srv6s_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/srv6s_cell.sv =====
// one byte cell of the header hold chain
module srv6s_cell (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);
  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= d_i;
    end
  end

  assign q_o = byte_q;
endmodule

// ===== design/srv6s_hold.sv =====
// header hold: a chain of byte cells shifting toward the head
module srv6s_hold (
  input  logic                  clk_i,
  input  srv6s_pkg::hold_ctl_t  hold_ctl_i,
  output srv6s_pkg::hold_taps_t taps_o
);
  import srv6s_pkg::*;

  logic [7:0] chain [HOLD_DEPTH];

  for (genvar k = 0; k < HOLD_DEPTH; k++) begin : g_cell
    logic [7:0] d;
    if (k == HOLD_DEPTH - 1) begin : g_tail
      assign d = hold_ctl_i.din;
    end else begin : g_mid
      assign d = chain[k + 1];
    end
    srv6s_cell u_cell (
      .clk_i (clk_i),
      .en_i  (hold_ctl_i.shift),
      .d_i   (d),
      .q_o   (chain[k])
    );
  end

  // once the chain is full, byte j of the frame sits in cell j
  assign taps_o.head = chain[0];
  assign taps_o.b12  = chain[12];
  assign taps_o.b13  = chain[13];
  assign taps_o.b18  = chain[18];
  assign taps_o.b19  = chain[19];
  assign taps_o.b20  = chain[20];
  assign taps_o.b54  = chain[54];
  assign taps_o.b55  = chain[55];
endmodule

// ===== design/srv6s_ctrl.sv =====
// frame sequencer: fill, padding of short frames, decide, release of the hold and streaming
`include "srv6_routing_header_strip_top_defines.svh"

module srv6s_ctrl #(
  parameter int MAX_SEGMENTS    = 8,
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  srv6s_pkg::in_beat_t   in_beat_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  output srv6s_pkg::out_beat_t  out_beat_o,
  input  logic                  out_ready_i,
  output srv6s_pkg::hold_ctl_t  hold_ctl_o,
  input  srv6s_pkg::hold_taps_t taps_i
);
  import srv6s_pkg::*;

  localparam int CapInt = (MAX_FRAME_BYTES < COUNT_MAX) ? MAX_FRAME_BYTES : COUNT_MAX;
  localparam logic [COUNT_WIDTH-1:0] CountCap = COUNT_WIDTH'(CapInt);
  localparam logic [6:0] SegLimit = 7'(MAX_SEGMENTS);
  localparam logic [COUNT_WIDTH-1:0] LastHeld = COUNT_WIDTH'(HOLD_DEPTH - 1);

  state_e                  state_q, state_d;
  mode_e                   mode_q, mode_d;
  logic [COUNT_WIDTH-1:0]  byte_count_q, byte_count_d;
  logic [CNT_WIDTH-1:0]    fill_q, fill_d;
  logic [CNT_WIDTH-1:0]    drain_cnt_q, drain_cnt_d;
  logic [CNT_WIDTH-1:0]    drain_total_q, drain_total_d;
  logic                    short_q, short_d;
  logic                    end_seen_q, end_seen_d;
  logic [1:0]              last_verdict_q, last_verdict_d;
  logic [STRIP_WIDTH-1:0]  strip_len_q, strip_len_d;
  logic [7:0]              inner_nh_q, inner_nh_d;
  logic                    drop_q, drop_d;
  logic [15:0]             pl_q, pl_d;
  logic [LIMIT_WIDTH-1:0]  keep_from_q, keep_from_d;
  logic [LIMIT_WIDTH-1:0]  need_q, need_d;
  logic                    out_valid_q, out_valid_d;
  out_beat_t               out_beat_q, out_beat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_FILL;
      mode_q         <= MODE_UNDECIDED;
      byte_count_q   <= '0;
      fill_q         <= '0;
      drain_cnt_q    <= '0;
      drain_total_q  <= '0;
      short_q        <= 1'b0;
      end_seen_q     <= 1'b0;
      last_verdict_q <= VERDICT_PASS;
      strip_len_q    <= '0;
      inner_nh_q     <= '0;
      drop_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      mode_q         <= mode_d;
      byte_count_q   <= byte_count_d;
      fill_q         <= fill_d;
      drain_cnt_q    <= drain_cnt_d;
      drain_total_q  <= drain_total_d;
      short_q        <= short_d;
      end_seen_q     <= end_seen_d;
      last_verdict_q <= last_verdict_d;
      strip_len_q    <= strip_len_d;
      inner_nh_q     <= inner_nh_d;
      drop_q         <= drop_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q        <= pl_d;
    keep_from_q <= keep_from_d;
    need_q      <= need_d;
    out_beat_q  <= out_beat_d;
  end

  always_comb begin
    logic                   slot_free;
    logic                   accept;
    logic                   routing;
    logic                   is_last;
    logic [7:0]             edited;
    logic [STRIP_WIDTH-1:0] strip_new;
    logic [LIMIT_WIDTH-1:0] tail_need;
    logic [COUNT_WIDTH:0]   frame_len;

    state_d        = state_q;
    mode_d         = mode_q;
    byte_count_d   = byte_count_q;
    fill_d         = fill_q;
    drain_cnt_d    = drain_cnt_q;
    drain_total_d  = drain_total_q;
    short_d        = short_q;
    end_seen_d     = end_seen_q;
    last_verdict_d = last_verdict_q;
    strip_len_d    = strip_len_q;
    inner_nh_d     = inner_nh_q;
    drop_d         = drop_q;
    pl_d           = pl_q;
    keep_from_d    = keep_from_q;
    need_d         = need_q;
    out_beat_d     = out_beat_q;

    slot_free = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;

    in_ready_o = 1'b0;
    hold_ctl_o.shift = 1'b0;
    hold_ctl_o.din   = in_beat_i.data_byte;

    routing = (taps_i.b12 == ETH_TYPE_HI) && (taps_i.b13 == ETH_TYPE_LO) &&
              (taps_i.b20 == NH_ROUTING);
    strip_new = STRIP_WIDTH'({taps_i.b55, 3'b000}) + STRIP_WIDTH'(8);
    tail_need = LIMIT_WIDTH'(strip_new) + LIMIT_WIDTH'(TAIL_BYTES);
    is_last = (drain_cnt_q == drain_total_q - CNT_WIDTH'(1));
    frame_len = {1'b0, byte_count_q} + (COUNT_WIDTH + 1)'(1);
    accept = 1'b0;

    // header bytes rewritten on release of a stripped frame
    edited = taps_i.head;
    if (mode_q == MODE_STRIP) begin
      priority case (drain_cnt_q)
        CNT_WIDTH'(18): edited = pl_q[15:8];
        CNT_WIDTH'(19): edited = pl_q[7:0];
        CNT_WIDTH'(20): edited = inner_nh_q;
        default:        edited = taps_i.head;
      endcase
    end

    unique case (state_q)
      S_FILL: begin
        in_ready_o = 1'b1;
        accept = in_valid_i;
        if (accept) begin
          hold_ctl_o.shift = 1'b1;
          if (byte_count_q == LastHeld) begin
            state_d = S_DECIDE;
            short_d = 1'b0;
            end_seen_d = in_beat_i.frame_end;
            byte_count_d = in_beat_i.frame_end ? '0 : byte_count_q + COUNT_WIDTH'(1);
          end else if (in_beat_i.frame_end) begin
            state_d = S_ALIGN;
            short_d = 1'b1;
            end_seen_d = 1'b1;
            drain_total_d = CNT_WIDTH'(frame_len);
            fill_d = CNT_WIDTH'(frame_len);
            byte_count_d = '0;
          end else begin
            byte_count_d = byte_count_q + COUNT_WIDTH'(1);
          end
        end
      end
      S_ALIGN: begin
        // pad a short frame so that byte j lands in cell j
        hold_ctl_o.shift = 1'b1;
        fill_d = fill_q + CNT_WIDTH'(1);
        if (fill_q == CNT_WIDTH'(HOLD_DEPTH - 1)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DRAIN;
        drain_cnt_d = '0;
        if (short_q) begin
          mode_d = MODE_UNDECIDED;
          last_verdict_d = ((drain_total_q >= CNT_WIDTH'(HDR_BYTES)) && routing) ?
                           VERDICT_DROP : VERDICT_PASS;
        end else if (!routing) begin
          mode_d = MODE_PASS;
          drain_total_d = CNT_WIDTH'(HOLD_DEPTH);
          last_verdict_d = VERDICT_PASS;
        end else begin
          mode_d = MODE_STRIP;
          drain_total_d = CNT_WIDTH'(HDR_BYTES);
          last_verdict_d = VERDICT_DROP;
          strip_len_d = strip_new;
          inner_nh_d = taps_i.b54;
          drop_d = (taps_i.b55[7:1] > SegLimit) ||
                   ((taps_i.b54 != NH_TCP) && (taps_i.b54 != NH_UDP));
          pl_d = {taps_i.b18, taps_i.b19} - 16'(strip_new);
          keep_from_d = LIMIT_WIDTH'(strip_new) + LIMIT_WIDTH'(HDR_BYTES);
          need_d = (tail_need < LIMIT_WIDTH'(MIN_FRAME)) ? LIMIT_WIDTH'(MIN_FRAME) : tail_need;
        end
      end
      S_DRAIN: begin
        if (slot_free) begin
          hold_ctl_o.shift = 1'b1;
          out_valid_d = 1'b1;
          out_beat_d.out_byte = edited;
          out_beat_d.out_end = is_last && end_seen_q;
          out_beat_d.verdict = (is_last && end_seen_q) ? last_verdict_q : VERDICT_PASS;
          drain_cnt_d = drain_cnt_q + CNT_WIDTH'(1);
          if (is_last) begin
            if (end_seen_q) begin
              state_d = S_FILL;
              mode_d = MODE_UNDECIDED;
            end else begin
              state_d = S_STREAM;
            end
          end
        end
      end
      S_STREAM: begin
        in_ready_o = slot_free;
        accept = in_valid_i && slot_free;
        if (accept) begin
          out_beat_d.out_byte = in_beat_i.data_byte;
          out_beat_d.out_end = in_beat_i.frame_end;
          out_beat_d.verdict = VERDICT_PASS;
          if (mode_q == MODE_PASS) begin
            out_valid_d = 1'b1;
          end else if (in_beat_i.frame_end) begin
            out_valid_d = 1'b1;
            out_beat_d.verdict = (drop_q || (frame_len < (COUNT_WIDTH + 1)'(need_q))) ?
                                 VERDICT_DROP : VERDICT_STRIP;
          end else if (byte_count_q >= COUNT_WIDTH'(keep_from_q)) begin
            // routing header bytes are dropped, the rest goes through
            out_valid_d = 1'b1;
          end
          if (in_beat_i.frame_end) begin
            state_d = S_FILL;
            mode_d = MODE_UNDECIDED;
            byte_count_d = '0;
          end else if (byte_count_q < CountCap) begin
            byte_count_d = byte_count_q + COUNT_WIDTH'(1);
          end
        end
      end
      default: begin
        state_d = S_FILL;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `SRV6S_ASSERT_IMPL(a_drain_in_range, clk_i, rst_ni, state_q == S_DRAIN, drain_cnt_q < drain_total_q)
  `SRV6S_ASSERT_IMPL(a_verdict_on_end, clk_i, rst_ni, out_valid_q && !out_beat_q.out_end, out_beat_q.verdict == VERDICT_PASS)
  `SRV6S_ASSERT_IMPL(a_stream_decided, clk_i, rst_ni, state_q == S_STREAM, mode_q != MODE_UNDECIDED)
  `SRV6S_ASSERT_IMPL(a_fill_in_hold, clk_i, rst_ni, state_q == S_FILL, byte_count_q < COUNT_WIDTH'(HOLD_DEPTH))
endmodule

// ===== design/srv6_routing_header_strip_top.sv =====
// top level of the srv6 routing header strip block
// Takes an Ethernet frame one byte per beat and removes the SRv6 routing
// header of IPv6 frames that carry one, fixing up the IPv6 payload length
// and next header, and marks the frame's last beat with its verdict. The
// first 56 bytes of each frame go into a 56-cell shift chain; while it fills,
// one byte is taken per cycle and nothing is emitted. On the 56th byte the
// decide state follows, then the chain is released at one beat per cycle
// while the output takes them (56 beats for a passed frame, 54 for a stripped
// one) with the input held off. A frame that ends before its 56th byte is
// padded to line up in the chain, goes through the decide state and is
// released as len beats. After the header the rest of the frame streams at
// one byte per cycle; the output register takes a new byte only when it is
// empty or its waiting byte is taken, so an output stall holds off the input.
module srv6_routing_header_strip_top #(
  parameter int MAX_SEGMENTS    = 8,
  parameter int MAX_FRAME_BYTES = 16383
) (
  input logic            clk_i,
  input logic            rst_ni,
  srv6s_stream_if.sink   in_i,
  srv6s_stream_if.source out_o
);
  import srv6s_pkg::*;

  hold_ctl_t  hold_ctl;
  hold_taps_t taps;
  in_beat_t   in_beat;
  out_beat_t  out_beat;
  logic       in_ready;
  logic       out_valid;

  assign in_beat = in_i.payload;

  srv6s_hold u_hold (
    .clk_i      (clk_i),
    .hold_ctl_i (hold_ctl),
    .taps_o     (taps)
  );

  srv6s_ctrl #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_beat_i   (in_beat),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_beat_o  (out_beat),
    .out_ready_i (out_o.ready),
    .hold_ctl_o  (hold_ctl),
    .taps_i      (taps)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_beat;
endmodule

// ===== test/tb_srv6_routing_header_strip_top.sv =====
// testbench of the srv6 routing header strip block, checked beat by beat against a predictor
module tb_srv6_routing_header_strip_top;
  import srv6s_pkg::*;

  localparam int SEG_LIMIT    = 8;
  localparam int FRAME_CAP    = 128;
  localparam int POS_CAP      = (FRAME_CAP < COUNT_MAX) ? FRAME_CAP : COUNT_MAX;
  localparam int RAND_FRAMES  = 2;
  localparam int DRAIN_CYCLES = 200;
  localparam int SHOW_LIMIT   = 10;
  localparam int GAP_MAX      = 14;

  typedef enum logic [1:0] {
    FR_OTHER,
    FR_IPV6,
    FR_SRH
  } frame_kind_e;

  // nh is the ipv6 next header for FR_IPV6 and the inner next header for FR_SRH
  typedef struct packed {
    frame_kind_e kind;
    int          len;
    logic [7:0]  ext_len;
    logic [7:0]  nh;
    logic [15:0] pl;
    logic        typed;
    logic [1:0]  verdict;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  srv6s_stream_if #(.payload_t(in_beat_t))  in_ch ();
  srv6s_stream_if #(.payload_t(out_beat_t)) out_ch ();

  srv6_routing_header_strip_top #(
    .MAX_SEGMENTS   (SEG_LIMIT),
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  frame_row_t dir_rows [3] = '{
    '{FR_OTHER, 1,     8'd0,   8'd0,   16'h0000, 1'b1, VERDICT_PASS},
    '{FR_SRH,   56,    8'd18,  NH_TCP, 16'h0100, 1'b1, VERDICT_DROP},
    '{FR_SRH,   130,   8'd0,   NH_UDP, 16'h0040, 1'b1, VERDICT_STRIP}
  };

  // predictor state
  logic [7:0]             hold_q [HOLD_DEPTH];
  logic [COUNT_WIDTH-1:0] pos_q       = '0;
  logic [STRIP_WIDTH-1:0] strip_len_q = '0;
  logic [7:0]             inner_nh_q  = '0;
  mode_e                  mode_q      = MODE_UNDECIDED;
  logic                   drop_q      = 1'b0;

  out_beat_t  out_bytes_q [$];
  logic [7:0] frame_bytes [$];
  int         src_gap_max = 0;
  int         snk_gap_max = 0;
  int         bad_beats   = 0;

  function automatic logic routed_hdr();
    return hold_q[12] == ETH_TYPE_HI && hold_q[13] == ETH_TYPE_LO &&
           hold_q[20] == NH_ROUTING;
  endfunction

  function automatic void push_beat(logic [7:0] b, logic e, logic [1:0] v);
    out_beat_t o;
    o.out_byte = b;
    o.out_end  = e;
    o.verdict  = e ? v : VERDICT_PASS;
    out_bytes_q.push_back(o);
  endfunction

  function automatic void strip_step(logic [7:0] b, logic e);
    int          idx;
    int          need;
    logic [1:0]  v;
    logic [7:0]  o;
    logic [15:0] pl;
    idx = int'(pos_q);
    if (mode_q == MODE_UNDECIDED) begin
      hold_q[idx] = b;
      if (idx < HOLD_DEPTH - 1) begin
        if (e) begin
          // short frame leaves the hold as received
          v = (idx + 1 >= HDR_BYTES && routed_hdr()) ? VERDICT_DROP : VERDICT_PASS;
          for (int i = 0; i <= idx; i++) push_beat(hold_q[i], i == idx, v);
        end
      end else if (!routed_hdr()) begin
        mode_q = MODE_PASS;
        for (int i = 0; i < HOLD_DEPTH; i++)
          push_beat(hold_q[i], e && i == HOLD_DEPTH - 1, VERDICT_PASS);
      end else begin
        mode_q      = MODE_STRIP;
        strip_len_q = {1'b0, hold_q[55], 3'b000} + 12'd8;
        inner_nh_q  = hold_q[54];
        drop_q      = (hold_q[55][7:1] > SEG_LIMIT) ||
                      (inner_nh_q != NH_TCP && inner_nh_q != NH_UDP);
        pl = {hold_q[18], hold_q[19]} - {4'd0, strip_len_q};
        for (int i = 0; i < HDR_BYTES; i++) begin
          o = hold_q[i];
          if (i == 18) o = pl[15:8];
          else if (i == 19) o = pl[7:0];
          else if (i == 20) o = inner_nh_q;
          // a frame ending on the decide byte never shows a tail
          push_beat(o, e && i == HDR_BYTES - 1, VERDICT_DROP);
        end
      end
    end else if (mode_q == MODE_PASS) begin
      push_beat(b, e, VERDICT_PASS);
    end else if (e) begin
      // last byte goes out even inside the routing header
      need = TAIL_BYTES + int'(strip_len_q);
      if (need < MIN_FRAME) need = MIN_FRAME;
      push_beat(b, 1'b1, (drop_q || idx + 1 < need) ? VERDICT_DROP : VERDICT_STRIP);
    end else if (idx >= HDR_BYTES + int'(strip_len_q)) begin
      push_beat(b, 1'b0, VERDICT_PASS);
    end
    if (e) begin
      pos_q  = '0;
      mode_q = MODE_UNDECIDED;
    end else if (pos_q < POS_CAP) begin
      pos_q = pos_q + 1'b1;
    end
  endfunction

  function automatic void check_beat(out_beat_t got);
    out_beat_t want;
    if (out_bytes_q.size() == 0) begin
      bad_beats++;
      if (bad_beats <= SHOW_LIMIT)
        $display("unexpected beat: byte %02h end %0b verdict %0d",
                 got.out_byte, got.out_end, got.verdict);
      return;
    end
    want = out_bytes_q.pop_front();
    if (got.out_byte !== want.out_byte || got.out_end !== want.out_end ||
        got.verdict !== want.verdict) begin
      bad_beats++;
      if (bad_beats <= SHOW_LIMIT)
        $display("beat mismatch: exp %02h/%0b/%0d got %02h/%0b/%0d",
                 want.out_byte, want.out_end, want.verdict,
                 got.out_byte, got.out_end, got.verdict);
    end
  endfunction

  function automatic void build_frame(frame_row_t r);
    logic [7:0] b;
    frame_bytes.delete();
    for (int i = 0; i < r.len; i++) begin
      b = 8'($urandom);
      if (r.kind != FR_OTHER) begin
        if (i == 12) b = ETH_TYPE_HI;
        if (i == 13) b = ETH_TYPE_LO;
        if (i == 20) b = (r.kind == FR_SRH) ? NH_ROUTING : r.nh;
      end
      if (r.kind == FR_SRH) begin
        if (i == 18) b = r.pl[15:8];
        if (i == 19) b = r.pl[7:0];
        if (i == 54) b = r.nh;
        if (i == 55) b = r.ext_len;
      end
      frame_bytes.push_back(b);
    end
    // keep other frames off the ipv6 ethertype
    if (r.kind == FR_OTHER && r.len > 13 && frame_bytes[12] == ETH_TYPE_HI &&
        frame_bytes[13] == ETH_TYPE_LO)
      frame_bytes[13] = ~ETH_TYPE_LO;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    in_beat_t beat;
    gap = $urandom_range(0, src_gap_max);
    beat.data_byte = b;
    beat.frame_end = e;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    strip_step(b, e);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_row_t r);
    build_frame(r);
    if (r.len > 1000) begin
      src_gap_max = 0;
      snk_gap_max = 0;
    end else begin
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
    end
    for (int i = 0; i < r.len; i++) send_byte(frame_bytes[i], i == r.len - 1);
    if (r.typed) out_bytes_q[$].verdict = r.verdict;
  endtask

  initial begin
    frame_row_t r;
    int         pick;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[k]) send_frame(dir_rows[k]);
    for (int n = 0; n < RAND_FRAMES; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) r.kind = FR_OTHER;
      else if (pick < 25) r.kind = FR_IPV6;
      else r.kind = FR_SRH;
      if ($urandom_range(0, 99) < 80) r.ext_len = 8'($urandom_range(0, 17));
      else r.ext_len = 8'($urandom_range(18, 255));
      if ($urandom_range(0, 99) < 80) r.nh = ($urandom_range(0, 1) != 0) ? NH_TCP : NH_UDP;
      else r.nh = 8'($urandom);
      r.pl      = 16'($urandom);
      r.typed   = 1'b0;
      r.verdict = VERDICT_PASS;
      r.len     = $urandom_range(1, 24);
      send_frame(r);
    end
    in_ch.valid <= 1'b0;
    while (out_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    bad_beats += out_bytes_q.size();
    if (bad_beats == 0) begin
      $display("tb_srv6_routing_header_strip_top: PASS");
    end else begin
      $display("tb_srv6_routing_header_strip_top: FAIL");
    end
    $finish;
  end

  // output side: random stalls before each beat
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, snk_gap_max);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      check_beat(out_ch.payload);
      @(negedge clk_i);
    end
  end

  initial begin
    #40_000_000;
    $display("tb_srv6_routing_header_strip_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/srv6s_pkg.sv
design/srv6s_stream_if.sv
design/srv6s_cell.sv
design/srv6s_hold.sv
design/srv6s_ctrl.sv
design/srv6_routing_header_strip_top.sv
test/tb_srv6_routing_header_strip_top.sv
